[rtl/core/scr_pkg.sv]
`timescale 1ns / 1ps
// Package for the stereo comb/allpass reverb: default line lengths,
// fixed-point constants, sequencer state type and a saturation helper.
package scr_pkg;

    localparam int unsigned COMB_DELAY_A    = 1426;
    localparam int unsigned COMB_DELAY_B    = 1781;
    localparam int unsigned COMB_DELAY_C    = 1973;
    localparam int unsigned COMB_DELAY_D    = 2098;
    localparam int unsigned ALLPASS_DELAY_A = 241;
    localparam int unsigned ALLPASS_DELAY_B = 807;

    localparam int unsigned NUM_LINES    = 6;
    localparam int unsigned NUM_COMBS    = 4;
    localparam int unsigned POS_W        = 12;
    localparam int unsigned AMOUNT_W     = 15;
    localparam int unsigned SAMPLE_W     = 16;
    localparam int unsigned PROD_W       = 36;

    localparam logic [14:0] DECAY_BASE   = 15'd17039;
    localparam logic [17:0] DECAY_SPAN   = 18'd13107;
    localparam logic [14:0] BYPASS_LIMIT = 15'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DMUL,
        S_DADD,
        S_RD,
        S_CMUL,
        S_CADD,
        S_AP,
        S_WR,
        S_MMUL,
        S_MADD,
        S_DONE
    } t_state;

    function automatic logic signed [15:0] sat16(input logic signed [35:0] x);
        logic signed [15:0] r;
        if (x > 36'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -36'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/scr_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/stereo_comb_allpass_reverb.sv]
`timescale 1ns / 1ps
// Stereo reverb: four feedback combs and two series allpasses per channel.
// Uses scr_pkg and six scr_ram instances, each holding both channels.
// After reset the lines are zeroed, one address per cycle, up to the length of
// the longest line (2098 by default); no item is taken during that time.
// An active item steps through the decay states, then read, comb or allpass and write
// states for each line and the mix states before its result is registered; one shared
// multiplier serves the decay, eight comb products and two mix products, and each line
// is read once. A bypassed item (amount of three or less) goes straight to the output
// state. One item is in flight, and a stalled result holds the block until taken.
module stereo_comb_allpass_reverb #(
    parameter int unsigned P_COMB_DELAY_A    = scr_pkg::COMB_DELAY_A,
    parameter int unsigned P_COMB_DELAY_B    = scr_pkg::COMB_DELAY_B,
    parameter int unsigned P_COMB_DELAY_C    = scr_pkg::COMB_DELAY_C,
    parameter int unsigned P_COMB_DELAY_D    = scr_pkg::COMB_DELAY_D,
    parameter int unsigned P_ALLPASS_DELAY_A = scr_pkg::ALLPASS_DELAY_A,
    parameter int unsigned P_ALLPASS_DELAY_B = scr_pkg::ALLPASS_DELAY_B
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_left_in,
    input  logic signed [15:0]  i_right_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [15:0]  o_left_out,
    output logic signed [15:0]  o_right_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [14:0]         i_cfg_amount
);

    localparam int unsigned LEN [scr_pkg::NUM_LINES] = '{
        P_COMB_DELAY_A, P_COMB_DELAY_B, P_COMB_DELAY_C, P_COMB_DELAY_D,
        P_ALLPASS_DELAY_A, P_ALLPASS_DELAY_B};
    localparam int unsigned MAX_AB  = (P_COMB_DELAY_A > P_COMB_DELAY_B) ?
                                      P_COMB_DELAY_A : P_COMB_DELAY_B;
    localparam int unsigned MAX_CD  = (P_COMB_DELAY_C > P_COMB_DELAY_D) ?
                                      P_COMB_DELAY_C : P_COMB_DELAY_D;
    localparam int unsigned MAX_EF  = (P_ALLPASS_DELAY_A > P_ALLPASS_DELAY_B) ?
                                      P_ALLPASS_DELAY_A : P_ALLPASS_DELAY_B;
    localparam int unsigned MAX_ABCD = (MAX_AB > MAX_CD) ? MAX_AB : MAX_CD;
    localparam int unsigned MAX_LEN  = (MAX_ABCD > MAX_EF) ? MAX_ABCD : MAX_EF;
    localparam logic [2:0]  LAST_COMB = 3'(scr_pkg::NUM_COMBS - 1);
    localparam logic [2:0]  LAST_LINE = 3'(scr_pkg::NUM_LINES - 1);

    scr_pkg::t_state    r_state, n_state;
    logic [11:0]        r_clr, n_clr;
    logic [2:0]         r_line, n_line;
    logic               r_ch, n_ch;
    logic [14:0]        r_amount;
    logic [14:0]        r_decay, n_decay;
    logic [11:0]        r_pos [scr_pkg::NUM_LINES];
    logic [11:0]        n_pos [scr_pkg::NUM_LINES];
    logic signed [15:0] r_x [2];
    logic signed [15:0] n_x [2];
    logic signed [17:0] r_sum [2];
    logic signed [17:0] n_sum [2];
    logic signed [15:0] r_acc [2];
    logic signed [15:0] n_acc [2];
    logic signed [15:0] r_new [2];
    logic signed [15:0] n_new [2];
    logic signed [35:0] r_prod, n_prod;
    logic               r_ovalid, n_ovalid;
    logic signed [15:0] r_out [2];
    logic signed [15:0] n_out [2];

    logic [31:0]        w_q [scr_pkg::NUM_LINES];
    logic [31:0]        w_qsel;
    logic signed [15:0] w_qch;
    logic signed [17:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [16:0] w_diff;
    logic signed [35:0] w_rnd;
    logic               w_slot_free;

    assign o_in_stall  = (r_state != scr_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_left_out  = r_out[0];
    assign o_right_out = r_out[1];

    generate
        for (genvar g = 0; g < scr_pkg::NUM_LINES; g++) begin : g_line
            localparam int unsigned AW = $clog2(LEN[g]);
            logic          w_clr_hit;
            logic          w_we;
            logic [AW-1:0] w_addr;
            assign w_clr_hit = (r_state == scr_pkg::S_CLEAR) && (r_clr < 12'(LEN[g]));
            assign w_we      = w_clr_hit ||
                               ((r_state == scr_pkg::S_WR) && (r_line == 3'(g)));
            assign w_addr    = (r_state == scr_pkg::S_CLEAR) ? r_clr[AW-1:0] :
                                                               r_pos[g][AW-1:0];
            scr_ram #(
                .WIDTH (32),
                .DEPTH (LEN[g])
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (w_we),
                .i_waddr (w_addr),
                .i_wdata ((r_state == scr_pkg::S_CLEAR) ? 32'd0 : {r_new[1], r_new[0]}),
                .i_re    ((r_state == scr_pkg::S_RD) && (r_line == 3'(g))),
                .i_raddr (w_addr),
                .o_rdata (w_q[g])
            );
        end
    endgenerate

    assign w_qsel      = w_q[r_line];
    assign w_qch       = r_ch ? w_qsel[31:16] : w_qsel[15:0];
    assign w_diff      = 17'(r_acc[r_ch]) - 17'(r_x[r_ch]);
    assign w_rnd       = (r_prod + 36'sd16384) >>> 15;
    assign w_slot_free = !r_ovalid || !i_out_stall;

    always_comb begin
        unique case (r_state)
            scr_pkg::S_DMUL: begin
                w_mul_a = scr_pkg::DECAY_SPAN;
                w_mul_b = {2'b00, r_amount};
            end
            scr_pkg::S_CMUL: begin
                w_mul_a = 18'(w_qch);
                w_mul_b = {2'b00, r_decay};
            end
            default: begin
                w_mul_a = 18'(w_diff);
                w_mul_b = {2'b00, r_amount};
            end
        endcase
    end

    always_comb begin
        logic signed [16:0] v_nd;
        logic signed [15:0] v_d;
        logic signed [15:0] v_y;
        v_nd     = '0;
        v_d      = '0;
        v_y      = '0;
        n_state  = r_state;
        n_clr    = r_clr;
        n_line   = r_line;
        n_ch     = r_ch;
        n_decay  = r_decay;
        n_pos    = r_pos;
        n_x      = r_x;
        n_sum    = r_sum;
        n_acc    = r_acc;
        n_new    = r_new;
        n_prod   = w_mul_a * w_mul_b;
        n_out    = r_out;
        n_ovalid = r_ovalid && i_out_stall;
        unique case (r_state)
            scr_pkg::S_CLEAR: begin
                n_clr = r_clr + 12'd1;
                if (r_clr == 12'(MAX_LEN - 1)) begin
                    n_state = scr_pkg::S_IDLE;
                end
            end
            scr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_x[0]   = i_left_in;
                    n_x[1]   = i_right_in;
                    n_acc[0] = i_left_in;
                    n_acc[1] = i_right_in;
                    n_sum[0] = '0;
                    n_sum[1] = '0;
                    n_line   = '0;
                    n_ch     = 1'b0;
                    n_state  = (r_amount <= scr_pkg::BYPASS_LIMIT) ? scr_pkg::S_DONE :
                                                                    scr_pkg::S_DMUL;
                end
            end
            scr_pkg::S_DMUL: begin
                n_state = scr_pkg::S_DADD;
            end
            scr_pkg::S_DADD: begin
                n_decay = scr_pkg::DECAY_BASE + w_rnd[14:0];
                n_state = scr_pkg::S_RD;
            end
            scr_pkg::S_RD: begin
                n_ch    = 1'b0;
                n_state = (r_line > LAST_COMB) ? scr_pkg::S_AP : scr_pkg::S_CMUL;
            end
            scr_pkg::S_CMUL: begin
                n_state = scr_pkg::S_CADD;
            end
            scr_pkg::S_CADD: begin
                n_new[r_ch] = scr_pkg::sat16(36'(r_x[r_ch]) + w_rnd);
                n_sum[r_ch] = r_sum[r_ch] + 18'(n_new[r_ch]);
                n_ch        = 1'b1;
                n_state     = r_ch ? scr_pkg::S_WR : scr_pkg::S_CMUL;
            end
            scr_pkg::S_AP: begin
                for (int c = 0; c < 2; c++) begin
                    v_d      = c[0] ? w_qsel[31:16] : w_qsel[15:0];
                    v_nd     = -17'(v_d);
                    v_y      = scr_pkg::sat16(36'(r_acc[c]) + 36'((v_nd + 17'sd1) >>> 1));
                    n_new[c] = v_y;
                    n_acc[c] = scr_pkg::sat16(36'(v_d) +
                                              36'((17'(v_y) + 17'sd1) >>> 1));
                end
                n_state = scr_pkg::S_WR;
            end
            scr_pkg::S_WR: begin
                if (r_line == LAST_COMB) begin
                    for (int c = 0; c < 2; c++) begin
                        n_acc[c] = 16'((r_sum[c] + 18'sd2) >>> 2);
                    end
                end
                n_ch = 1'b0;
                if (r_line == LAST_LINE) begin
                    n_state = scr_pkg::S_MMUL;
                end else begin
                    n_line  = r_line + 3'd1;
                    n_state = scr_pkg::S_RD;
                end
            end
            scr_pkg::S_MMUL: begin
                n_state = scr_pkg::S_MADD;
            end
            scr_pkg::S_MADD: begin
                n_acc[r_ch] = scr_pkg::sat16(36'(r_x[r_ch]) + w_rnd);
                n_ch        = 1'b1;
                if (r_ch) begin
                    for (int i = 0; i < scr_pkg::NUM_LINES; i++) begin
                        n_pos[i] = (13'(r_pos[i]) + 13'd1 >= 13'(LEN[i])) ? 12'd0 :
                                   r_pos[i] + 12'd1;
                    end
                    n_state = scr_pkg::S_DONE;
                end else begin
                    n_state = scr_pkg::S_MMUL;
                end
            end
            scr_pkg::S_DONE: begin
                if (w_slot_free) begin
                    n_out    = r_acc;
                    n_ovalid = 1'b1;
                    n_state  = scr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= scr_pkg::S_CLEAR;
            r_clr    <= '0;
            r_line   <= '0;
            r_ch     <= 1'b0;
            r_amount <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < scr_pkg::NUM_LINES; i++) begin
                r_pos[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_line   <= n_line;
            r_ch     <= n_ch;
            r_ovalid <= n_ovalid;
            r_pos    <= n_pos;
            if (i_cfg_valid) begin
                r_amount <= i_cfg_amount;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_decay <= n_decay;
        r_x     <= n_x;
        r_sum   <= n_sum;
        r_acc   <= n_acc;
        r_new   <= n_new;
        r_prod  <= n_prod;
        r_out   <= n_out;
    end

endmodule

[rtl/core/scr_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for stereo_comb_allpass_reverb and its bind statement.
// No package dependencies.
module scr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_left_out,
    input logic [15:0] o_right_out
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("block not stalled and empty after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken while one is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_left_out) && $stable(o_right_out)))
        else $error("stalled result changed");

endmodule

bind stereo_comb_allpass_reverb scr_checker u_scr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_left_out  (o_left_out),
    .o_right_out (o_right_out)
);
